FILE: design/fixed_capacity_array_list_top_macros.svh
// Assertion helpers shared by the list design.
`ifndef FIXED_CAPACITY_ARRAY_LIST_TOP_MACROS_SVH
`define FIXED_CAPACITY_ARRAY_LIST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FACL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/facl_pkg.sv
package facl_pkg;

    // Storage geometry, fixed by the field widths of the interface.
    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 32;
    localparam int POS_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int CAP_W      = 5;

    // Found position reported when a search misses.
    localparam logic signed [POS_W-1:0] FOUND_NONE = -5'sd1;

    // Register indexes on the configuration port.
    localparam logic REG_CAPACITY = 1'b0;

    // Request operation codes.
    typedef enum logic [2:0] {
        OP_GET     = 3'd0,
        OP_FIND    = 3'd1,
        OP_INSERT  = 3'd2,
        OP_REPLACE = 3'd3,
        OP_SWAP    = 3'd4,
        OP_REMOVE  = 3'd5,
        OP_CLEAR   = 3'd6
    } t_op;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_FINISH
    } t_state;

    // Per-cell command for one cycle.
    typedef struct packed {
        logic capture;     // register the compare against the new key
        logic load;        // take the broadcast word
        logic shift_up;    // take the word of the lower neighbour
        logic shift_down;  // take the word of the upper neighbour
    } t_cell_cmd;

endpackage

FILE: design/fixed_capacity_array_list_top.sv
// Bounded ordered list of 32-bit words held in a row of 16 storage cells.
// Requests arrive on the input channel (i_in_valid / o_in_stall) and carry an
// operation, one or two positions and a word. Each request gives exactly one
// result on the output channel (o_out_valid / i_out_stall): ok, the word read
// or removed, the position found by a search and the entry count afterwards.
// A request is handled in order: in the accepting cycle every cell compares its
// word with the search key; in the finish state, once the output register can
// take the result, the cells shift, load or swap together and the result is
// written to the output register. The block takes no new request until the
// current one has finished.
// A result waiting in the output register does not block the next request;
// a request that finishes while that result is still stalled is held in the
// finish state, with its input stalled, until the result is taken.
// The capacity register (APB, address 0) takes effect for the next request
// and is to be written by the user only while the block is idle; the block does not enforce this.
// Reset empties the list, sets the capacity to 16 and clears both channels;
// the cell contents are not cleared, as no empty position is ever read.
`include "fixed_capacity_array_list_top_macros.svh"

module fixed_capacity_array_list_top (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // Request channel
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic [2:0]                                i_op,
    input  logic [facl_pkg::POS_W-1:0]                i_position,
    input  logic [facl_pkg::IDX_W-1:0]                i_second_position,
    input  logic [facl_pkg::ITEM_WIDTH-1:0]           i_item_in,
    // Result channel
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic                                      o_ok,
    output logic [facl_pkg::ITEM_WIDTH-1:0]           o_item_out,
    output logic signed [facl_pkg::POS_W-1:0]         o_found_at,
    output logic [facl_pkg::CNT_W-1:0]                o_count,
    // Configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [2:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int DEPTH = facl_pkg::DEPTH;
    localparam int IW    = facl_pkg::ITEM_WIDTH;

    // Control state
    facl_pkg::t_state                    r_state, n_state;
    logic [facl_pkg::CAP_W-1:0]          r_cap;
    logic [facl_pkg::CNT_W-1:0]          r_count, n_count;

    // Held request
    facl_pkg::t_op                       r_op;
    logic [facl_pkg::POS_W-1:0]          r_pos;
    logic [facl_pkg::IDX_W-1:0]          r_pos2;
    logic [IW-1:0]                       r_item;

    // Output register
    logic                                r_out_valid;
    logic                                r_ok;
    logic [IW-1:0]                       r_item_out;
    logic signed [facl_pkg::POS_W-1:0]   r_found_at;
    logic [facl_pkg::CNT_W-1:0]          r_count_out;

    // Cell row
    facl_pkg::t_cell_cmd                 w_cmd   [DEPTH];
    logic [IW-1:0]                       w_word  [DEPTH];
    logic [IW-1:0]                       w_load  [DEPTH];
    logic [DEPTH-1:0]                    w_hit;
    logic [DEPTH-1:0]                    w_hit_q;

    // Decode of the held request
    logic                                w_accept;
    logic                                w_finish_go;
    logic                                w_cfg_write;
    logic [facl_pkg::CNT_W-1:0]          w_eff_cap;
    logic [IW-1:0]                       w_rd1, w_rd2;
    logic [facl_pkg::IDX_W-1:0]          w_first;
    logic                                w_any;
    logic                                w_ins_ok, w_rep_ok, w_swap_ok, w_rem_ok;
    logic                                n_ok;
    logic [IW-1:0]                       n_item_out;
    logic signed [facl_pkg::POS_W-1:0]   n_found_at;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_cfg_write = psel && penable && pwrite && pready;

    // Configuration register and read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= facl_pkg::CAP_W'(DEPTH);
        end else if (w_cfg_write && (paddr[2] == facl_pkg::REG_CAPACITY)) begin
            r_cap <= pwdata[facl_pkg::CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == facl_pkg::REG_CAPACITY) ? 32'(r_cap) : '0;
    assign pready = 1'b1;

    // A capacity above the storage depth acts as the depth.
    assign w_eff_cap = (r_cap > facl_pkg::CAP_W'(DEPTH)) ? facl_pkg::CNT_W'(DEPTH)
                                                           : facl_pkg::CNT_W'(r_cap);

    // Sequencer: next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            facl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = facl_pkg::S_FINISH;
                end
            end
            facl_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = facl_pkg::S_IDLE;
                end
            end
            default: n_state = facl_pkg::S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        o_in_stall  = 1'b1;
        w_finish_go = 1'b0;
        case (r_state)
            facl_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
            end
            facl_pkg::S_FINISH: begin
                w_finish_go = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall  = 1'b1;
                w_finish_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= facl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= facl_pkg::t_op'(i_op);
            r_pos  <= i_position;
            r_pos2 <= i_second_position;
            r_item <= i_item_in;
        end
    end

    // Words at the two addressed positions, for get, remove and swap.
    assign w_rd1 = w_word[r_pos[facl_pkg::IDX_W-1:0]];
    assign w_rd2 = w_word[r_pos2];

    // Lowest qualified match at or after the start position.
    assign w_any = |w_hit_q;
    always_comb begin
        w_first = '0;
        for (int k = DEPTH - 1; k >= 0; k--) begin
            if (w_hit_q[k]) begin
                w_first = facl_pkg::IDX_W'(k);
            end
        end
    end

    // Operation decode and result.
    always_comb begin
        w_ins_ok   = 1'b0;
        w_rep_ok   = 1'b0;
        w_swap_ok  = 1'b0;
        w_rem_ok   = 1'b0;
        n_ok       = 1'b0;
        n_item_out = '0;
        n_found_at = facl_pkg::FOUND_NONE;
        n_count    = r_count;
        case (r_op)
            facl_pkg::OP_GET: begin
                if (r_pos < r_count) begin
                    n_ok       = 1'b1;
                    n_item_out = w_rd1;
                end
            end
            facl_pkg::OP_FIND: begin
                if (w_any) begin
                    n_ok       = 1'b1;
                    n_found_at = facl_pkg::POS_W'(w_first);
                end
            end
            facl_pkg::OP_INSERT: begin
                if ((r_pos <= r_count) && (r_count < w_eff_cap)) begin
                    w_ins_ok = 1'b1;
                    n_ok     = 1'b1;
                    n_count  = r_count + facl_pkg::CNT_W'(1);
                end
            end
            facl_pkg::OP_REPLACE: begin
                if (r_pos < r_count) begin
                    w_rep_ok = 1'b1;
                    n_ok     = 1'b1;
                end
            end
            facl_pkg::OP_SWAP: begin
                if ((r_pos < r_count) && (facl_pkg::CNT_W'(r_pos2) < r_count)) begin
                    w_swap_ok = 1'b1;
                    n_ok      = 1'b1;
                end
            end
            facl_pkg::OP_REMOVE: begin
                if (r_pos < r_count) begin
                    w_rem_ok   = 1'b1;
                    n_ok       = 1'b1;
                    n_item_out = w_rd1;
                    n_count    = r_count - facl_pkg::CNT_W'(1);
                end
            end
            facl_pkg::OP_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_finish_go) begin
            r_count <= n_count;
        end
    end

    // Output register: refilled when a request finishes, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish_go) begin
            r_ok        <= n_ok;
            r_item_out  <= n_item_out;
            r_found_at  <= n_found_at;
            r_count_out <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_ok;
    assign o_item_out  = r_item_out;
    assign o_found_at  = r_found_at;
    assign o_count     = r_count_out;

    // Cell row: commands, neighbour links and match qualification.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [facl_pkg::POS_W-1:0] CELL_POS = facl_pkg::POS_W'(g);
        localparam logic [facl_pkg::IDX_W-1:0] CELL_IDX = facl_pkg::IDX_W'(g);

        logic [IW-1:0] w_left;
        logic [IW-1:0] w_right;

        assign w_cmd[g].capture    = w_accept;
        assign w_cmd[g].load       = w_finish_go &&
                                     (((w_ins_ok || w_rep_ok) && (r_pos == CELL_POS)) ||
                                      (w_swap_ok && ((r_pos == CELL_POS) ||
                                                     (r_pos2 == CELL_IDX))));
        assign w_cmd[g].shift_up   = w_finish_go && w_ins_ok && (CELL_POS > r_pos);
        assign w_cmd[g].shift_down = w_finish_go && w_rem_ok && (CELL_POS >= r_pos);

        // A swap loads each addressed cell with the other one's word.
        assign w_load[g] = !w_swap_ok ? r_item :
                           (r_pos == CELL_POS) ? w_rd2 : w_rd1;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_left
            assign w_left = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_word[g];
        end else begin : g_inner_right
            assign w_right = w_word[g+1];
        end

        assign w_hit_q[g] = w_hit[g] && (CELL_POS >= r_pos) && (CELL_POS < r_count);

        facl_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd[g]),
            .i_load_word  (w_load[g]),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .i_key        (i_item_in),
            .o_word       (w_word[g]),
            .o_hit        (w_hit[g])
        );
    end

    // Checks on the sequencing and the entry count.
    `FACL_ASSERT_NEXT(a_accept_to_finish, w_accept, r_state == facl_pkg::S_FINISH, "accepted request did not move to finish")
    `FACL_ASSERT_NOW(a_insert_room, w_finish_go && w_ins_ok, r_count < w_eff_cap, "insert accepted with the list full")
    `FACL_ASSERT_NEXT(a_insert_count, w_finish_go && w_ins_ok, r_count == $past(r_count) + 5'd1, "insert did not grow the count by one")
    `FACL_ASSERT_NEXT(a_remove_count, w_finish_go && w_rem_ok, r_count == $past(r_count) - 5'd1, "remove did not shrink the count by one")
    `FACL_ASSERT_NEXT(a_result_on_finish, w_finish_go, r_out_valid, "finished request left no result")

endmodule

FILE: design/facl_cell.sv
module facl_cell (
    input  logic                               i_clk,
    input  facl_pkg::t_cell_cmd                i_cmd,
    input  logic [facl_pkg::ITEM_WIDTH-1:0]    i_load_word,
    input  logic [facl_pkg::ITEM_WIDTH-1:0]    i_left_word,
    input  logic [facl_pkg::ITEM_WIDTH-1:0]    i_right_word,
    input  logic [facl_pkg::ITEM_WIDTH-1:0]    i_key,
    output logic [facl_pkg::ITEM_WIDTH-1:0]    o_word,
    output logic                               o_hit
);

    logic [facl_pkg::ITEM_WIDTH-1:0] r_word;
    logic                            r_hit;

    // Stored word: a direct load wins over a shift from either neighbour.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_load_word;
        end else if (i_cmd.shift_up) begin
            r_word <= i_left_word;
        end else if (i_cmd.shift_down) begin
            r_word <= i_right_word;
        end
    end

    // Compare result, taken when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hit <= (r_word == i_key);
        end
    end

    assign o_word = r_word;
    assign o_hit  = r_hit;

endmodule
